### rtl/prime_factorization_spf_sieve_assert.svh
// assertion macros for the rtl of the spf sieve block, included by spf_factor
// expects signals named clk and arst_n in the module that uses them
`ifndef PRIME_FACTORIZATION_SPF_SIEVE_ASSERT_SVH
`define PRIME_FACTORIZATION_SPF_SIEVE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SPF_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spf assertion failed");
// next-cycle implication
`define SPF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spf assertion failed");
`else
`define SPF_ASSERT_IMPL(lbl, ante, cons)
`define SPF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/spf_pkg.sv
// constants and types of the smallest-prime-factor sieve block
// no dependencies
package spf_pkg;

	localparam int MAX_VALUE   = 65535;
	localparam int DEPTH       = MAX_VALUE + 1;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int WORD_W      = ADDR_W;
	localparam int VALUE_W     = 16;
	localparam int EXP_W       = 5;
	localparam int CNT_W       = $clog2(ADDR_W + 1);
	localparam int FIRST_PRIME = 2;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		word_t wdata;
		addr_t raddr;
	} ram_req_t;

	typedef struct packed {
		logic  start;
		addr_t dividend;
		addr_t divisor;
	} div_req_t;

	typedef struct packed {
		logic  done;
		addr_t quotient;
	} div_rsp_t;

endpackage

### rtl/spf_query_if.sv
// query channel: one value to factor per item
// depends on spf_pkg
interface spf_query_if
	import spf_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

### rtl/spf_result_if.sv
// result channel: one prime with its exponent per item
// depends on spf_pkg
interface spf_result_if
	import spf_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] prime;
	logic [EXP_W-1:0]   exponent;
	logic               last;
	logic               empty_res;

	modport source (output valid, output prime, output exponent, output last,
		output empty_res, input ready);
	modport sink (input valid, input prime, input exponent, input last,
		input empty_res, output ready);
endinterface

### rtl/spf_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module spf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/spf_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on spf_pkg
module spf_div
	import spf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	addr_t             rem_q;
	addr_t             quo_q;
	addr_t             dvs_q;
	logic [ADDR_W:0]   trial;
	logic [ADDR_W:0]   diff;

	assign trial = {rem_q, quo_q[ADDR_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ADDR_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			// msb of the difference set means the trial went negative
			if (!diff[ADDR_W]) begin
				rem_q <= diff[ADDR_W-1:0];
				quo_q <= {quo_q[ADDR_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[ADDR_W-1:0];
				quo_q <= {quo_q[ADDR_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule

### rtl/spf_sieve.sv
// sieve sequencer that builds the smallest-prime-factor table after reset
// depends on spf_pkg; drives the table ram through a ram_req_t
module spf_sieve
	import spf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  word_t    rdata,
	output ram_req_t req,
	output logic     done
);
	localparam int I_W  = ADDR_W + 1;
	localparam int M_W  = ADDR_W + 2;
	localparam int SQ_W = 2 * ADDR_W + 2;

	typedef enum logic [2:0] {
		S_FILL,
		S_CHK_RD,
		S_CHK_EV,
		S_MARK,
		S_DONE
	} state_t;

	state_t          state_q;
	addr_t           fill_q;
	logic [I_W-1:0]  i_q;
	logic [SQ_W-1:0] sq_q;
	logic [M_W-1:0]  m_q;
	logic            mk_vld_s1;
	addr_t           mk_addr_s1;
	logic            done_q;
	logic            m_in_range;
	logic            sq_in_range;
	logic [I_W-1:0]  i_next;
	logic [SQ_W-1:0] sq_next;

	assign m_in_range  = m_q <= M_W'(MAX_VALUE);
	assign sq_in_range = sq_q <= SQ_W'(MAX_VALUE);
	assign i_next      = i_q + I_W'(2);
	// (i+2)^2 = i^2 + 4i + 4
	assign sq_next     = sq_q + SQ_W'({i_q, 2'b00}) + SQ_W'(4);

	always_comb begin
		req.we    = 1'b0;
		req.waddr = fill_q;
		req.wdata = '0;
		req.raddr = ADDR_W'(i_q);
		case (state_q)
			S_FILL: begin
				req.we    = 1'b1;
				req.waddr = fill_q;
				req.wdata = (fill_q >= ADDR_W'(FIRST_PRIME) && !fill_q[0]) ?
					WORD_W'(FIRST_PRIME) : '0;
			end
			S_CHK_EV: begin
				// an unlabeled odd entry is prime
				req.we    = (rdata == '0);
				req.waddr = ADDR_W'(i_q);
				req.wdata = WORD_W'(i_q);
			end
			S_MARK: begin
				req.raddr = ADDR_W'(m_q);
			end
			default: begin
			end
		endcase
		// marking write for the read issued in the previous cycle
		if (mk_vld_s1 && rdata == '0) begin
			req.we    = 1'b1;
			req.waddr = mk_addr_s1;
			req.wdata = WORD_W'(i_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_FILL;
			fill_q     <= '0;
			i_q        <= I_W'(3);
			sq_q       <= SQ_W'(9);
			m_q        <= '0;
			mk_vld_s1  <= 1'b0;
			mk_addr_s1 <= '0;
			done_q     <= 1'b0;
		end else begin
			mk_vld_s1 <= 1'b0;
			case (state_q)
				S_FILL: begin
					fill_q <= fill_q + 1'b1;
					if (fill_q == ADDR_W'(MAX_VALUE)) begin
						state_q <= S_CHK_RD;
					end
				end
				S_CHK_RD: begin
					if (i_q > I_W'(MAX_VALUE)) begin
						state_q <= S_DONE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_CHK_EV;
					end
				end
				S_CHK_EV: begin
					if (rdata == '0 && sq_in_range) begin
						m_q     <= M_W'(sq_q);
						state_q <= S_MARK;
					end else begin
						i_q     <= i_next;
						sq_q    <= sq_next;
						state_q <= S_CHK_RD;
					end
				end
				S_MARK: begin
					mk_vld_s1  <= m_in_range;
					mk_addr_s1 <= ADDR_W'(m_q);
					if (m_in_range) begin
						m_q <= m_q + M_W'({i_q, 1'b0});
					end else begin
						// last marking write lands this cycle, before the next check read
						i_q     <= i_next;
						sq_q    <= sq_next;
						state_q <= S_CHK_RD;
					end
				end
				S_DONE: begin
					done_q <= 1'b1;
				end
				default: begin
					state_q <= S_FILL;
				end
			endcase
		end
	end

	assign done = done_q;
endmodule

### rtl/spf_factor.sv
// query sequencer: table lookups and divisions, one result item per prime
// depends on spf_pkg, spf_query_if, spf_result_if and the assertion macros
`include "prime_factorization_spf_sieve_assert.svh"

module spf_factor
	import spf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tbl_rdy,
	spf_query_if.sink           query,
	spf_result_if.source        result,
	output addr_t               rd_addr,
	input  word_t               rd_data,
	output div_req_t            div_req,
	input  div_rsp_t            div_rsp
);
	typedef enum logic [2:0] {
		Q_IDLE,
		Q_LOOK,
		Q_DIV,
		Q_CMP,
		Q_EMIT
	} state_t;

	state_t           state_q;
	addr_t            n_q;
	word_t            p_q;
	word_t            nxt_q;
	logic [EXP_W-1:0] e_q;
	logic             start_q;
	word_t            res_p_q;
	logic [EXP_W-1:0] res_e_q;
	logic             res_last_q;
	logic             res_empty_q;
	logic             out_vld_q;
	word_t            out_prime_q;
	logic [EXP_W-1:0] out_exp_q;
	logic             out_last_q;
	logic             out_empty_q;
	logic             in_ok;
	logic             no_factor;
	logic             out_free;

	assign in_ok     = tbl_rdy && state_q == Q_IDLE;
	assign no_factor = query.value < VALUE_W'(FIRST_PRIME) ||
		32'(query.value) > MAX_VALUE;
	assign out_free  = !out_vld_q || result.ready;

	always_comb begin
		case (state_q)
			Q_IDLE:  rd_addr = ADDR_W'(query.value);
			Q_DIV:   rd_addr = div_rsp.quotient;
			default: rd_addr = n_q;
		endcase
	end

	assign div_req.start    = start_q;
	assign div_req.dividend = n_q;
	assign div_req.divisor  = p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= Q_IDLE;
			start_q     <= 1'b0;
			out_vld_q   <= 1'b0;
			n_q         <= '0;
			p_q         <= '0;
			nxt_q       <= '0;
			e_q         <= '0;
			res_p_q     <= '0;
			res_e_q     <= '0;
			res_last_q  <= 1'b0;
			res_empty_q <= 1'b0;
			out_prime_q <= '0;
			out_exp_q   <= '0;
			out_last_q  <= 1'b0;
			out_empty_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_vld_q && result.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				Q_IDLE: begin
					if (query.valid && in_ok) begin
						if (no_factor) begin
							res_p_q     <= '0;
							res_e_q     <= '0;
							res_last_q  <= 1'b1;
							res_empty_q <= 1'b1;
							state_q     <= Q_EMIT;
						end else begin
							n_q     <= ADDR_W'(query.value);
							state_q <= Q_LOOK;
						end
					end
				end
				Q_LOOK: begin
					p_q     <= rd_data;
					e_q     <= '0;
					start_q <= 1'b1;
					state_q <= Q_DIV;
				end
				Q_DIV: begin
					if (div_rsp.done) begin
						n_q <= div_rsp.quotient;
						e_q <= e_q + 1'b1;
						if (div_rsp.quotient == ADDR_W'(1)) begin
							res_p_q     <= p_q;
							res_e_q     <= e_q + 1'b1;
							res_last_q  <= 1'b1;
							res_empty_q <= 1'b0;
							state_q     <= Q_EMIT;
						end else begin
							state_q <= Q_CMP;
						end
					end
				end
				Q_CMP: begin
					// same smallest factor means the prime divides once more
					if (rd_data == p_q) begin
						start_q <= 1'b1;
						state_q <= Q_DIV;
					end else begin
						res_p_q     <= p_q;
						res_e_q     <= e_q;
						res_last_q  <= 1'b0;
						res_empty_q <= 1'b0;
						nxt_q       <= rd_data;
						state_q     <= Q_EMIT;
					end
				end
				Q_EMIT: begin
					if (out_free) begin
						out_vld_q   <= 1'b1;
						out_prime_q <= res_p_q;
						out_exp_q   <= res_e_q;
						out_last_q  <= res_last_q;
						out_empty_q <= res_empty_q;
						if (res_last_q) begin
							state_q <= Q_IDLE;
						end else begin
							p_q     <= nxt_q;
							e_q     <= '0;
							start_q <= 1'b1;
							state_q <= Q_DIV;
						end
					end
				end
				default: begin
					state_q <= Q_IDLE;
				end
			endcase
		end
	end

	assign query.ready      = in_ok;
	assign result.valid     = out_vld_q;
	assign result.prime     = VALUE_W'(out_prime_q);
	assign result.exponent  = out_exp_q;
	assign result.last      = out_last_q;
	assign result.empty_res = out_empty_q;

	`SPF_ASSERT_IMPL(a_divisor_prime, start_q, p_q >= WORD_W'(FIRST_PRIME))
	`SPF_ASSERT_IMPL(a_empty_shape, out_vld_q && out_empty_q,
		out_last_q && out_prime_q == '0 && out_exp_q == '0)
	`SPF_ASSERT_IMPL(a_factor_exp, out_vld_q && !out_empty_q, out_exp_q != '0)
	`SPF_ASSERT_NEXT(a_busy_after_accept, query.valid && query.ready, !query.ready)
endmodule

### rtl/prime_factorization_spf_sieve.sv
// Prime factorization by a smallest-prime-factor table. After reset the block
// sweeps the table ram once to seed it (even entries from 2 up get 2, the
// rest 0), then runs the odd sieve over it, checking each odd entry from 3 up
// and marking multiples of each new prime with a read-modify-write pipeline;
// no query item is taken before the build ends. Each query then costs one
// table read, and per prime factor occurrence one division plus one table
// read: the divider gives one quotient bit per cycle, and a result may wait
// on the receiver. Results leave in ascending prime order; the final one has
// last set, and a value of 0, 1 or beyond the table gives a single result
// flagged empty_res.
// depends on spf_pkg, the channel interfaces, spf_ram, spf_div, spf_sieve, spf_factor
module prime_factorization_spf_sieve
	import spf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	spf_query_if.sink    query,
	spf_result_if.source result
);
	ram_req_t sv_req;
	logic     tbl_rdy;
	word_t    rdata;
	addr_t    fac_raddr;
	addr_t    raddr;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// the sieve owns the read port until the table is built
	assign raddr = tbl_rdy ? fac_raddr : sv_req.raddr;

	spf_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (sv_req.we),
		.waddr (sv_req.waddr),
		.wdata (sv_req.wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	spf_sieve u_sieve (
		.clk    (clk),
		.arst_n (arst_n),
		.rdata  (rdata),
		.req    (sv_req),
		.done   (tbl_rdy)
	);

	spf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	spf_factor u_factor (
		.clk     (clk),
		.arst_n  (arst_n),
		.tbl_rdy (tbl_rdy),
		.query   (query),
		.result  (result),
		.rd_addr (fac_raddr),
		.rd_data (rdata),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);
endmodule
